@@ hw/rtl/whi_pkg.sv @@
// Package for the word hash index core: widths, reset values, register codes,
// back-end state type and the per-byte mixing function.
// No dependencies.
package whi_pkg;

	localparam int HASH_W  = 32;
	localparam int INDEX_W = 31;
	localparam int BYTE_W  = 8;
	localparam int CNT_W   = $clog2(INDEX_W);

	localparam logic [HASH_W-1:0]  SEED_RESET       = 32'd1159241;
	localparam logic [INDEX_W-1:0] TABLE_SIZE_RESET = 31'd1;

	// configuration register indexes
	localparam logic REG_SEED       = 1'b0;
	localparam logic REG_TABLE_SIZE = 1'b1;

	typedef logic [HASH_W-1:0]  hash_t;
	typedef logic [INDEX_W-1:0] index_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_HOLD
	} bk_state_t;

	// h ^ ((h << 5) + sext(b) + (h >> 2)), mod 2^32
	function automatic hash_t mix_byte(hash_t h, logic [BYTE_W-1:0] b);
		hash_t b_ext;
		hash_t sum;
		b_ext = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
		sum   = (h << 5) + b_ext + (h >> 2);
		return h ^ sum;
	endfunction

endpackage

@@ hw/rtl/word_bitwise_hash_index_core.sv @@
// Byte-serial string hash with bucket index. Bytes are hashed one per cycle
// as they arrive while full is low; full rises only while the two-entry queue
// in front of the divider holds two finished words. A word's last byte queues
// its masked hash; the back end pops it to load the divider, the bit-serial
// remainder unit works through it, and the result is registered as its bucket
// index when the output is free. The divider takes no new word before that.
// Uses whi_pkg, whi_front, whi_fifo and whi_back.
module word_bitwise_hash_index_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [whi_pkg::BYTE_W-1:0]   word_byte,
	input  logic                         last_byte,
	output logic                         empty,
	input  logic                         pop,
	output whi_pkg::index_t              bucket_index,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [whi_pkg::HASH_W-1:0]   cfg_wdata
);
	import whi_pkg::*;

	hash_t  seed_q;
	index_t table_size_q;
	logic   q_full;
	logic   q_empty;
	logic   q_push;
	logic   q_pop;
	index_t q_wdata;
	index_t q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q       <= SEED_RESET;
			table_size_q <= TABLE_SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEED:       seed_q       <= cfg_wdata;
				REG_TABLE_SIZE: table_size_q <= cfg_wdata[INDEX_W-1:0];
				default:        seed_q       <= seed_q;
			endcase
		end
	end

	whi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.word_byte (word_byte),
		.last_byte (last_byte),
		.seed      (seed_q),
		.q_full    (q_full),
		.full      (full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	whi_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (INDEX_W)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.full    (q_full),
		.empty   (q_empty)
	);

	whi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_rdata),
		.table_size   (table_size_q),
		.pop          (pop),
		.q_pop        (q_pop),
		.empty        (empty),
		.bucket_index (bucket_index)
	);

endmodule

@@ hw/rtl/whi_fifo.sv @@
// Small register queue between the hashing front end and the divider.
// Depends on nothing but its parameters.
module whi_fifo #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_idx_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_idx_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_idx_q <= (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
			end
			if (do_rd) begin
				rd_idx_q <= (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/whi_front.sv @@
// Front end: takes one byte per cycle while full is low, folds it into the
// running hash and queues the masked hash on a word's last byte. Uses whi_pkg.
module whi_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [whi_pkg::BYTE_W-1:0]   word_byte,
	input  logic                         last_byte,
	input  whi_pkg::hash_t               seed,
	input  logic                         q_full,
	output logic                         full,
	output logic                         q_push,
	output whi_pkg::index_t              q_data
);
	import whi_pkg::*;

	hash_t accum_q;
	logic  started_q;
	hash_t h_in;
	hash_t h_new;
	logic  accept;

	// stall every byte while the queue is full, so a last byte is never dropped
	assign full   = q_full;
	assign accept = push && !q_full;
	assign h_in   = started_q ? accum_q : seed;
	assign h_new  = mix_byte(h_in, word_byte);
	assign q_push = accept && last_byte;
	assign q_data = h_new[INDEX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			accum_q   <= SEED_RESET;
		end else if (accept) begin
			started_q <= !last_byte;
			accum_q   <= h_new;
		end
	end

endmodule

@@ hw/rtl/whi_back.sv @@
// Back end: restoring divider, one quotient bit per cycle, leaving the
// remainder (the masked hash for a zero divisor) in an output register. Uses whi_pkg.
module whi_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  whi_pkg::index_t  q_data,
	input  whi_pkg::index_t  table_size,
	input  logic             pop,
	output logic             q_pop,
	output logic             empty,
	output whi_pkg::index_t  bucket_index
);
	import whi_pkg::*;

	localparam logic [CNT_W-1:0] TOP_BIT = CNT_W'(INDEX_W - 1);

	bk_state_t         state_q;
	bk_state_t         state_d;
	logic              load_out;
	index_t            dividend_q;
	index_t            rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	index_t            out_q;
	logic [INDEX_W:0]  trial;
	logic [INDEX_W:0]  diff;

	assign trial        = {rem_q, dividend_q[cnt_q]};
	assign diff         = trial - {1'b0, table_size};
	assign empty        = !out_valid_q;
	assign bucket_index = out_q;

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (cnt_q == '0) begin
					state_d = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (!out_valid_q || pop) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (q_pop) begin
			cnt_q <= TOP_BIT;
		end else if (state_q == BK_DIV) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dividend_q <= q_data;
			rem_q      <= '0;
		end else if (state_q == BK_DIV) begin
			rem_q <= (trial >= {1'b0, table_size}) ? diff[INDEX_W-1:0] : trial[INDEX_W-1:0];
		end
		// a zero divisor passes the masked hash through
		if (load_out) begin
			out_q <= (table_size == '0) ? dividend_q : rem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ verif/tb_word_bitwise_hash_index_core.sv @@
`timescale 1ns / 100ps
// Testbench for word_bitwise_hash_index_core: feeds words byte by byte, checks every
// bucket index against an in-bench hash predictor across several register settings.
// Depends on whi_pkg and the core RTL.
module tb_word_bitwise_hash_index_core;

	import whi_pkg::*;

	localparam int SETTLE     = 40;
	localparam int STALL_MAX  = 5000;
	localparam int HOLD_LEN   = 400;
	localparam int PHASE_SIZE = 180;

	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              fin;
	} byte_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	logic [BYTE_W-1:0]   word_byte = '0;
	logic                last_byte = 1'b0;
	logic                empty;
	logic                pop = 1'b0;
	index_t              bucket_index;
	logic                cfg_we = 1'b0;
	logic                cfg_index = REG_SEED;
	logic [HASH_W-1:0]   cfg_wdata = '0;

	byte_item_t pending_bytes[$];
	index_t     bucket_expect[$];

	// predictor state and register copies
	hash_t  seed_cfg = SEED_RESET;
	index_t tsize_cfg = TABLE_SIZE_RESET;
	hash_t  run_hash = SEED_RESET;
	logic   in_word = 1'b0;

	int errors = 0;
	int bytes_seen = 0;
	int words_seen = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int stall_cnt = 0;
	logic byte_taken = 1'b0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	word_bitwise_hash_index_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.word_byte    (word_byte),
		.last_byte    (last_byte),
		.empty        (empty),
		.pop          (pop),
		.bucket_index (bucket_index),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic hash_t hash_step(hash_t h, logic [BYTE_W-1:0] b);
		hash_t wide;
		wide = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
		return h ^ ((h << 5) + wide + (h >> 2));
	endfunction

	function automatic void absorb_byte(logic [BYTE_W-1:0] b, logic fin);
		hash_t  h;
		index_t idx;
		h = in_word ? run_hash : seed_cfg;
		h = hash_step(h, b);
		if (!fin) begin
			run_hash = h;
			in_word = 1'b1;
		end else begin
			idx = h[INDEX_W-1:0];
			// zero divisor passes the masked hash through
			if (tsize_cfg != '0)
				idx = idx % tsize_cfg;
			bucket_expect.push_back(idx);
			run_hash = seed_cfg;
			in_word = 1'b0;
			words_seen++;
		end
	endfunction

	task automatic report_mismatch(string what, index_t want, index_t got);
		$display("MISMATCH %s: expected %0d got %0d at %0t", what, want, got, $realtime);
		errors++;
	endtask

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'h80;
			3: return 8'h7f;
			default: return BYTE_W'($urandom);
		endcase
	endfunction

	function automatic int add_random_word();
		int len;
		len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
		for (int i = 0; i < len; i++)
			pending_bytes.push_back('{pick_byte(), i == len - 1});
		return len;
	endfunction

	function automatic void add_word(logic [BYTE_W-1:0] b, logic fin);
		pending_bytes.push_back('{b, fin});
	endfunction

	task automatic write_reg(logic idx, logic [HASH_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SEED)
			seed_cfg = data;
		else
			tsize_cfg = data[INDEX_W-1:0];
		reg_writes++;
	endtask

	// all words sent and answered, then give the back end time to go quiet;
	// checked at the rising edge, where the sender's outputs have settled
	task automatic wait_idle();
		while (pending_bytes.size() != 0 || push || bucket_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		byte_item_t nxt;
		logic go;
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || byte_taken) begin
			go = pending_bytes.size() != 0 &&
				((bytes_seen >= 700 && bytes_seen < 900) || $urandom_range(99) >= 12);
			if (go) begin
				nxt = pending_bytes.pop_front();
				push <= 1'b1;
				word_byte <= nxt.b;
				last_byte <= nxt.fin;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			pop <= 1'b0;
		end else if (!hold_done && results_seen >= 80 && pending_bytes.size() > 100) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
			pop <= 1'b0;
		end else begin
			pop <= (results_seen >= 150 && results_seen < 200) || $urandom_range(99) >= 12;
		end
	end

	// input side: predict on every accepted word byte
	always @(posedge clk) begin
		byte_taken = arst_n && push && !full;
		if (byte_taken) begin
			absorb_byte(word_byte, last_byte);
			bytes_seen++;
		end
	end

	// result side
	always @(posedge clk) begin
		index_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (bucket_expect.size() == 0) begin
				report_mismatch("unexpected bucket_index", '0, bucket_index);
			end else begin
				want = bucket_expect.pop_front();
				if (bucket_index !== want)
					report_mismatch("bucket_index", want, bucket_index);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || cfg_we)
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_MAX) begin
				$display("Timeout: no handshake for %0d cycles", STALL_MAX);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int added;
		logic [INDEX_W-1:0] ts;
		logic [HASH_W-1:0] sd;

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset register values
		add_word(8'h00, 1'b1);
		add_word(8'hff, 1'b1);
		add_word(8'h41, 1'b0);
		add_word(8'h42, 1'b0);
		add_word(8'h43, 1'b1);
		wait_idle();

		// zero seed, zero table size: masked hash comes out as is
		write_reg(REG_SEED, '0);
		write_reg(REG_TABLE_SIZE, '0);
		add_word(8'h00, 1'b1);
		add_word(8'h80, 1'b1);
		add_word(8'h7f, 1'b1);
		add_word(8'hff, 1'b0);
		add_word(8'hff, 1'b0);
		add_word(8'h80, 1'b1);
		wait_idle();

		// all-ones seed, widest table; bit 31 of the write data is dropped
		write_reg(REG_SEED, 32'hffffffff);
		write_reg(REG_TABLE_SIZE, 32'hffffffff);
		add_word(8'hff, 1'b1);
		add_word(8'h00, 1'b0);
		add_word(8'h7f, 1'b0);
		add_word(8'h80, 1'b0);
		add_word(8'h01, 1'b1);
		wait_idle();

		// seed change inside a word only applies to the next word
		write_reg(REG_SEED, 32'h12345678);
		write_reg(REG_TABLE_SIZE, 32'd1000);
		add_word(8'h55, 1'b0);
		add_word(8'haa, 1'b0);
		wait_idle();
		write_reg(REG_SEED, 32'ha5a5a5a5);
		add_word(8'h33, 1'b1);
		add_word(8'h33, 1'b1);
		wait_idle();

		for (int k = 0; k < 8; k++) begin
			case (k)
				0: ts = INDEX_W'($urandom_range(16, 1));
				1: ts = '1;
				2: ts = '0;
				4: ts = INDEX_W'(1) << $urandom_range(INDEX_W - 1);
				5: ts = INDEX_W'($urandom_range(1000, 2));
				7: ts = INDEX_W'(1);
				default: ts = INDEX_W'($urandom);
			endcase
			sd = (k == 2) ? '0 : (k == 5) ? '1 : HASH_W'($urandom);
			write_reg(REG_SEED, sd);
			write_reg(REG_TABLE_SIZE, {1'($urandom_range(1)), ts});
			added = 0;
			while (added < PHASE_SIZE)
				added += add_random_word();
			wait_idle();
		end

		while (bucket_expect.size() != 0) begin
			report_mismatch("bucket_index never arrived", bucket_expect.pop_front(), '0);
		end

		$display("Covered %0d bytes in %0d words over %0d register writes",
			bytes_seen, words_seen, reg_writes);
		$display("Checked %0d bucket indexes, %0d mismatches", results_seen, errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
